// ----- src/iirl_pkg.sv -----
// iirl_pkg: shared widths, operation and status codes, cell control struct
// for the indexed insert/remove list. No dependencies.
`default_nettype none

package iirl_pkg;

    localparam int CAPACITY = 16;
    localparam int POS_W    = 4;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = 5;
    localparam int CMP_W    = CNT_W + 1;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic load;
        logic take_prev;
        logic take_next;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- src/iirl_cell.sv -----
// iirl_cell: one list slot holding a handle and its filled flag.
// Loads a new handle or takes its lower or upper neighbor. Uses iirl_pkg.
`default_nettype none

module iirl_cell (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire iirl_pkg::t_cell_ctl    i_ctl,
    input  wire [iirl_pkg::VAL_W-1:0]   i_new_value,
    input  wire [iirl_pkg::VAL_W-1:0]   i_prev_value,
    input  wire                         i_prev_filled,
    input  wire [iirl_pkg::VAL_W-1:0]   i_next_value,
    input  wire                         i_next_filled,
    output logic [iirl_pkg::VAL_W-1:0]  o_value,
    output logic                        o_filled
);

    logic [iirl_pkg::VAL_W-1:0] r_value;
    logic [iirl_pkg::VAL_W-1:0] n_value;
    logic                       r_filled;
    logic                       n_filled;

    always_comb begin
        n_value  = r_value;
        n_filled = r_filled;
        if (i_ctl.load) begin
            n_value  = i_new_value;
            n_filled = 1'b1;
        end else if (i_ctl.take_prev) begin
            n_value  = i_prev_value;
            n_filled = i_prev_filled;
        end else if (i_ctl.take_next) begin
            n_value  = i_next_value;
            n_filled = i_next_filled;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (!i_rst_n) begin
            r_filled <= 1'b0;
        end else begin
            r_filled <= n_filled;
        end
    end

    assign o_value  = r_value;
    assign o_filled = r_filled;

endmodule

`default_nettype wire

// ----- src/indexed_insert_remove_list.sv -----
// indexed_insert_remove_list: positional handle list built as a row of slots.
// The result of an accepted transaction appears in the result register in the cycle after it is accepted.
// Throughput: one transaction per cycle while the output is not stalled; every slot shifts in the same cycle.
// Reset clears the count, all filled flags and the result valid; stored
// handles are not reset. Uses iirl_pkg and iirl_cell.
`default_nettype none

module indexed_insert_remove_list (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire [1:0]                   i_kind,
    input  wire [iirl_pkg::POS_W-1:0]   i_position,
    input  wire [iirl_pkg::VAL_W-1:0]   i_entry_value,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic [1:0]                  o_status,
    output logic [iirl_pkg::VAL_W-1:0]  o_read_value,
    output logic                        o_read_present,
    output logic [iirl_pkg::CNT_W-1:0]  o_entry_count
);

    localparam int CAP = iirl_pkg::CAPACITY;
    localparam int CW  = iirl_pkg::CMP_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAP);

    logic [iirl_pkg::CNT_W-1:0] r_count;
    logic [iirl_pkg::CNT_W-1:0] n_count;
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic [1:0]                 r_status;
    logic [iirl_pkg::VAL_W-1:0] r_read_value;
    logic                       r_read_present;
    logic [iirl_pkg::CNT_W-1:0] r_entry_count;

    logic [iirl_pkg::VAL_W-1:0] w_val [CAP];
    logic [CAP-1:0]             w_fill;

    logic            accept;
    logic [CW-1:0]   pos_ext;
    logic [CW-1:0]   cnt_ext;
    logic            ins_within;
    logic            ins_full;
    logic            ins_ok;
    logic            hit;
    logic            rem_ok;
    logic            rd_present;
    logic [1:0]      status;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    assign pos_ext    = CW'(i_position);
    assign cnt_ext    = CW'(r_count);
    assign ins_within = pos_ext <= cnt_ext;
    assign ins_full   = ins_within ? (cnt_ext >= CAP_C) : ((pos_ext + CW'(1)) > CAP_C);
    assign ins_ok     = (i_kind == iirl_pkg::KIND_INSERT) & ~ins_full;
    assign hit        = pos_ext < cnt_ext;
    assign rem_ok     = (i_kind == iirl_pkg::KIND_REMOVE) & hit;
    assign rd_present = (i_kind == iirl_pkg::KIND_READ) & hit & w_fill[i_position];

    always_comb begin
        status  = iirl_pkg::ST_DONE;
        n_count = r_count;
        case (i_kind)
            iirl_pkg::KIND_INSERT: begin
                if (ins_full) begin
                    status = iirl_pkg::ST_FULL;
                end else if (ins_within) begin
                    n_count = r_count + iirl_pkg::CNT_W'(1);
                end else begin
                    n_count = iirl_pkg::CNT_W'(pos_ext + CW'(1));
                end
            end
            iirl_pkg::KIND_READ: begin
                if (!hit) begin
                    status = iirl_pkg::ST_ABSENT;
                end
            end
            iirl_pkg::KIND_REMOVE: begin
                if (!hit) begin
                    status = iirl_pkg::ST_ABSENT;
                end else begin
                    n_count = r_count - iirl_pkg::CNT_W'(1);
                end
            end
            default: begin
                status = iirl_pkg::ST_DONE;
            end
        endcase
    end

    // row of slots
    for (genvar i = 0; i < CAP; i++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);
        iirl_pkg::t_cell_ctl        ctl;
        logic [iirl_pkg::VAL_W-1:0] prev_value;
        logic                       prev_filled;
        logic [iirl_pkg::VAL_W-1:0] next_value;
        logic                       next_filled;

        assign ctl = '{
            load:      accept & ins_ok & (pos_ext == IDX),
            take_prev: accept & ins_ok & (pos_ext < IDX),
            take_next: accept & rem_ok & (pos_ext <= IDX)
        };

        if (i == 0) begin : g_first
            assign prev_value  = '0;
            assign prev_filled = 1'b0;
        end else begin : g_mid_lo
            assign prev_value  = w_val[i-1];
            assign prev_filled = w_fill[i-1];
        end

        if (i == CAP - 1) begin : g_last
            assign next_value  = '0;
            assign next_filled = 1'b0;
        end else begin : g_mid_hi
            assign next_value  = w_val[i+1];
            assign next_filled = w_fill[i+1];
        end

        iirl_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_new_value   (i_entry_value),
            .i_prev_value  (prev_value),
            .i_prev_filled (prev_filled),
            .i_next_value  (next_value),
            .i_next_filled (next_filled),
            .o_value       (w_val[i]),
            .o_filled      (w_fill[i])
        );
    end

    always_comb begin
        n_out_valid = r_out_valid & i_out_stall;
        if (accept) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_count <= n_count;
            end
        end
        if (accept) begin
            r_status       <= status;
            r_read_value   <= rd_present ? w_val[i_position] : '0;
            r_read_present <= rd_present;
            r_entry_count  <= n_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_read_value   = r_read_value;
    assign o_read_present = r_read_present;
    assign o_entry_count  = r_entry_count;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_count) <= CAP_C)
        else $error("count above capacity");

    a_empty_above_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fill >> r_count) == '0)
        else $error("filled slot at or above count");

    a_present_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid & o_read_present |-> (o_status == iirl_pkg::ST_DONE))
        else $error("read present with bad status");

    a_result_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (o_entry_count == r_count))
        else $error("result count differs from list count");

    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept & rem_ok |=> (r_count == $past(r_count) - iirl_pkg::CNT_W'(1)))
        else $error("remove did not lower count");

endmodule

`default_nettype wire

// ----- bench/iirl_list_checker.sv -----
// iirl_list_checker: watches both channels of indexed_insert_remove_list, keeps
// its own copy of the list and compares every reply field by field.
// Depends on iirl_pkg.
`timescale 1ns / 100ps

module iirl_list_checker (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    input  wire                         i_in_stall,
    input  wire [1:0]                   i_kind,
    input  wire [iirl_pkg::POS_W-1:0]   i_position,
    input  wire [iirl_pkg::VAL_W-1:0]   i_entry_value,
    input  wire                         i_out_valid,
    input  wire                         i_out_stall,
    input  wire [1:0]                   i_status,
    input  wire [iirl_pkg::VAL_W-1:0]   i_read_value,
    input  wire                         i_read_present,
    input  wire [iirl_pkg::CNT_W-1:0]   i_entry_count,
    output int                          o_mismatch_count,
    output int                          o_owed_count
);

    typedef struct packed {
        logic [1:0]                 status;
        logic [iirl_pkg::VAL_W-1:0] value;
        logic                       present;
        logic [iirl_pkg::CNT_W-1:0] count;
    } t_list_reply;

    logic [iirl_pkg::VAL_W-1:0] shadow_value [iirl_pkg::CAPACITY];
    logic                       shadow_filled [iirl_pkg::CAPACITY];
    int                         shadow_count;
    t_list_reply                owed_replies [$];

    task automatic apply_list_op(input logic [1:0] kind, input int pos,
            input logic [iirl_pkg::VAL_W-1:0] value, output t_list_reply reply);
        int i;
        reply = '0;
        reply.status = iirl_pkg::ST_DONE;
        case (kind)
            iirl_pkg::KIND_INSERT: begin
                if (pos <= shadow_count) begin
                    if (shadow_count >= iirl_pkg::CAPACITY) begin
                        reply.status = iirl_pkg::ST_FULL;
                    end else begin
                        for (i = shadow_count; i > pos; i--) begin
                            shadow_value[i]  = shadow_value[i-1];
                            shadow_filled[i] = shadow_filled[i-1];
                        end
                        shadow_value[pos]  = value;
                        shadow_filled[pos] = 1'b1;
                        shadow_count++;
                    end
                end else if (pos + 1 > iirl_pkg::CAPACITY) begin
                    reply.status = iirl_pkg::ST_FULL;
                end else begin
                    // slots skipped over become empty
                    for (i = shadow_count; i < pos; i++) begin
                        shadow_value[i]  = '0;
                        shadow_filled[i] = 1'b0;
                    end
                    shadow_value[pos]  = value;
                    shadow_filled[pos] = 1'b1;
                    shadow_count = pos + 1;
                end
            end
            iirl_pkg::KIND_READ: begin
                if (pos < shadow_count) begin
                    if (shadow_filled[pos]) begin
                        reply.value   = shadow_value[pos];
                        reply.present = 1'b1;
                    end
                end else begin
                    reply.status = iirl_pkg::ST_ABSENT;
                end
            end
            iirl_pkg::KIND_REMOVE: begin
                if (pos >= shadow_count) begin
                    reply.status = iirl_pkg::ST_ABSENT;
                end else begin
                    for (i = pos; i + 1 < shadow_count; i++) begin
                        shadow_value[i]  = shadow_value[i+1];
                        shadow_filled[i] = shadow_filled[i+1];
                    end
                    shadow_count--;
                    shadow_value[shadow_count]  = '0;
                    shadow_filled[shadow_count] = 1'b0;
                end
            end
            default: begin
            end
        endcase
        reply.count = shadow_count[iirl_pkg::CNT_W-1:0];
    endtask

    task automatic compare_field(input string field,
            input logic [iirl_pkg::VAL_W-1:0] want,
            input logic [iirl_pkg::VAL_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            o_mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_list_reply reply;
        t_list_reply owed;
        if (!i_rst_n) begin
            for (int k = 0; k < iirl_pkg::CAPACITY; k++) begin
                shadow_value[k]  = '0;
                shadow_filled[k] = 1'b0;
            end
            shadow_count = 0;
            owed_replies.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (owed_replies.size() == 0) begin
                    $display({"%0t: unexpected transaction, expected none, ",
                              "actual status %0d value %0h present %0d count %0d"},
                             $time, i_status, i_read_value, i_read_present,
                             i_entry_count);
                    o_mismatch_count++;
                end else begin
                    owed = owed_replies.pop_front();
                    compare_field("status", iirl_pkg::VAL_W'(owed.status),
                                  iirl_pkg::VAL_W'(i_status));
                    compare_field("read_value", owed.value, i_read_value);
                    compare_field("read_present", iirl_pkg::VAL_W'(owed.present),
                                  iirl_pkg::VAL_W'(i_read_present));
                    compare_field("entry_count", iirl_pkg::VAL_W'(owed.count),
                                  iirl_pkg::VAL_W'(i_entry_count));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_list_op(i_kind, int'(i_position), i_entry_value, reply);
                owed_replies.push_back(reply);
            end
        end
        o_owed_count = owed_replies.size();
    end

endmodule

// ----- bench/tb.sv -----
// tb: drives indexed_insert_remove_list with directed and random transactions,
// idles both channels and gives the verdict. Depends on iirl_pkg,
// indexed_insert_remove_list and iirl_list_checker.
`timescale 1ns / 100ps

module tb;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_OPS  = 1450;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 120;

    logic                       clk;
    logic                       rst_n       = 1'b0;
    logic                       in_valid    = 1'b0;
    logic                       in_stall;
    logic [1:0]                 kind        = iirl_pkg::KIND_INSERT;
    logic [iirl_pkg::POS_W-1:0] position    = '0;
    logic [iirl_pkg::VAL_W-1:0] entry_value = '0;
    logic                       out_valid;
    logic                       out_stall   = 1'b0;
    logic [1:0]                 status;
    logic [iirl_pkg::VAL_W-1:0] read_value;
    logic                       read_present;
    logic [iirl_pkg::CNT_W-1:0] entry_count;
    int                         mismatch_count;
    int                         owed_count;
    int                         idle_cycles = 0;
    logic                       calm_sender = 1'b0;

    indexed_insert_remove_list dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_kind         (kind),
        .i_position     (position),
        .i_entry_value  (entry_value),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_status       (status),
        .o_read_value   (read_value),
        .o_read_present (read_present),
        .o_entry_count  (entry_count)
    );

    iirl_list_checker list_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_kind           (kind),
        .i_position       (position),
        .i_entry_value    (entry_value),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_status         (status),
        .i_read_value     (read_value),
        .i_read_present   (read_present),
        .i_entry_count    (entry_count),
        .o_mismatch_count (mismatch_count),
        .o_owed_count     (owed_count)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic offer(input logic [1:0] op, input logic [iirl_pkg::POS_W-1:0] pos,
            input logic [iirl_pkg::VAL_W-1:0] value);
        int gap;
        logic taken;
        gap = calm_sender ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= op;
        position    <= pos;
        entry_value <= value;
        do begin
            @(negedge clk);
            taken = (in_stall === 1'b0);
            @(posedge clk);
        end while (!taken);
    endtask

    task automatic wait_drained;
        in_valid <= 1'b0;
        do @(negedge clk); while (owed_count != 0);
        @(posedge clk);
    endtask

    initial begin : send_side
        int phase_left;
        int insert_weight;
        int pick;
        logic [1:0] op;
        logic [iirl_pkg::POS_W-1:0] pos;
        logic [iirl_pkg::VAL_W-1:0] value;
        phase_left = 0;
        insert_weight = 45;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, unused kind, handle zero
        offer(iirl_pkg::KIND_READ, 4'd0, 32'h0);
        offer(iirl_pkg::KIND_REMOVE, 4'd0, 32'h0);
        offer(KIND_UNUSED, 4'd9, 32'h1234_5678);
        offer(iirl_pkg::KIND_INSERT, 4'd0, 32'h0);
        offer(iirl_pkg::KIND_READ, 4'd0, 32'h0);
        // insert past the end leaves an empty gap
        offer(iirl_pkg::KIND_INSERT, 4'd5, 32'hFFFF_FFFF);
        offer(iirl_pkg::KIND_READ, 4'd3, 32'h0);
        offer(iirl_pkg::KIND_READ, 4'd5, 32'h0);
        offer(iirl_pkg::KIND_INSERT, 4'd0, 32'hA5A5_A5A5);
        offer(iirl_pkg::KIND_REMOVE, 4'd2, 32'h0);
        // fill to capacity, then refused inserts
        offer(iirl_pkg::KIND_INSERT, 4'd15, 32'h5A5A_5A5A);
        offer(iirl_pkg::KIND_INSERT, 4'd3, 32'hDEAD_BEEF);
        offer(iirl_pkg::KIND_INSERT, 4'd15, 32'hFFFF_FFFF);
        offer(iirl_pkg::KIND_READ, 4'd15, 32'h0);
        offer(iirl_pkg::KIND_REMOVE, 4'd15, 32'h0);
        offer(iirl_pkg::KIND_INSERT, 4'd15, 32'h0000_0001);
        offer(iirl_pkg::KIND_READ, 4'd14, 32'h0);
        offer(iirl_pkg::KIND_REMOVE, 4'd0, 32'h0);
        offer(iirl_pkg::KIND_REMOVE, 4'd14, 32'h0);
        offer(iirl_pkg::KIND_READ, 4'd15, 32'h0);
        offer(KIND_UNUSED, 4'd15, 32'hFFFF_FFFF);

        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(30, 90);
                case ($urandom_range(0, 2))
                    0: insert_weight = 20;
                    1: insert_weight = 45;
                    default: insert_weight = 70;
                endcase
                calm_sender = ($urandom_range(0, 3) == 0);
            end
            phase_left--;
            if (n == 500 || n == 1100) begin
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick >= 97) begin
                op = KIND_UNUSED;
            end else if (pick < insert_weight) begin
                op = iirl_pkg::KIND_INSERT;
            end else if (pick < insert_weight + (97 - insert_weight) / 2) begin
                op = iirl_pkg::KIND_READ;
            end else begin
                op = iirl_pkg::KIND_REMOVE;
            end
            pos = $urandom_range(0, 1) ? iirl_pkg::POS_W'($urandom_range(0, 3))
                                       : iirl_pkg::POS_W'($urandom_range(0, 15));
            value = ($urandom_range(0, 15) == 0) ? '0 : $urandom;
            offer(op, pos, value);
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && owed_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : reply_side
        int hold;
        int taken_count;
        logic taken;
        taken_count = 0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (taken_count == 250 || taken_count == 900) begin
                hold = HOLD_CYCLES;
            end else if (taken_count % 150 < 40) begin
                hold = 0;
            end else begin
                hold = $urandom_range(0, 10);
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do begin
                @(negedge clk);
                taken = (out_valid === 1'b1);
                @(posedge clk);
            end while (!taken);
            taken_count++;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
